// ===== src/two_pkg.sv =====
// Shared types, constants and helper functions of the tracking wheel odometry block.
`timescale 1ns / 1ps

package two_pkg;

    // Number formats
    localparam int FRACTION_BITS = 16;
    localparam int CORDIC_STEPS  = 16;
    localparam int CI_W          = $clog2(CORDIC_STEPS);
    localparam int MUL_SHIFT     = 30;

    // Angle and scale constants in Q30 unless noted
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint KINF_Q30  = 64'sd652032874;
    localparam longint CORDIC_X0 = KINF_Q30 +
        ((2 * CORDIC_STEPS < 63) ? ((KINF_Q30 * 2 / 3) >>> (2 * CORDIC_STEPS)) : 64'sd0);
    localparam longint PI_FB     = (PI_Q30 + 2 ** (29 - FRACTION_BITS)) >>> (30 - FRACTION_BITS);
    localparam longint TWO_PI_FB =
        (2 * PI_Q30 + 2 ** (29 - FRACTION_BITS)) >>> (30 - FRACTION_BITS);
    localparam longint HSCALE    = 18000 * 2 ** (30 - FRACTION_BITS);
    localparam longint ROT_DIV   = 36000;
    localparam longint MOTOR_DIV = 900;
    localparam longint HEAD_BASE = 45000;
    localparam longint HEAD_MOD  = 36000;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam logic [CFG_IDX_W-1:0] CFG_VDIA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDIA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR = 3'd4;

    // Operations of the shared serial arithmetic unit
    typedef logic [1:0] t_op;
    localparam t_op OP_MUL  = 2'd0;
    localparam t_op OP_DIVR = 2'd1;
    localparam t_op OP_MOD  = 2'd2;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] vertical_count;
        logic               vertical_ok;
        logic signed [31:0] left_motor_count;
        logic signed [31:0] right_motor_count;
        logic               motors_ok;
        logic signed [31:0] horizontal_count;
        logic signed [31:0] imu_rotation;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pose_x_out;
        logic signed [31:0] pose_y_out;
        logic signed [19:0] heading_out;
    } t_out_item;

    typedef struct packed {
        logic               start;
        t_op                op;
        logic               rnd;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_arith_req;

    typedef struct packed {
        logic               done;
        logic               busy;
        logic signed [63:0] res;
    } t_arith_rsp;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
        logic signed [63:0] v;
        case (i)
            5'd0: v = 64'sd843314857;
            5'd1: v = 64'sd497837829;
            5'd2: v = 64'sd263043837;
            5'd3: v = 64'sd133525159;
            5'd4: v = 64'sd67021687;
            5'd5: v = 64'sd33543516;
            5'd6: v = 64'sd16775851;
            5'd7: v = 64'sd8388437;
            5'd8: v = 64'sd4194283;
            5'd9: v = 64'sd2097149;
            default: v = (i <= 5'd30) ? (64'sd1 <<< (5'd30 - i)) : 64'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/two_in_if.sv =====
// Input channel of the odometry block: valid, ready and one sensor item.
`timescale 1ns / 1ps

interface two_in_if;
    logic                valid;
    logic                ready;
    two_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/two_out_if.sv =====
// Output channel of the odometry block: valid, ready and one pose item.
`timescale 1ns / 1ps

interface two_out_if;
    logic                valid;
    logic                ready;
    two_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/two_arith.sv =====
// Shared bit-serial multiplier and restoring divider of the odometry block.
`timescale 1ns / 1ps

module two_arith (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  two_pkg::t_arith_req  i_req,
    output two_pkg::t_arith_rsp  o_rsp
);

    localparam logic [2:0] AS_IDLE = 3'd0;
    localparam logic [2:0] AS_MUL  = 3'd1;
    localparam logic [2:0] AS_DIV  = 3'd2;
    localparam logic [2:0] AS_RND  = 3'd3;
    localparam logic [2:0] AS_OUT  = 3'd4;

    logic [2:0]         r_as;
    two_pkg::t_op       r_op;
    logic               r_rnd;
    logic               r_neg;
    logic               r_done;
    logic [63:0]        r_ma;
    logic [63:0]        r_mb;
    logic [63:0]        r_acc;
    logic [63:0]        r_q;
    logic [63:0]        r_d;
    logic [63:0]        r_rem;
    logic [5:0]         r_cnt;
    logic signed [63:0] r_res;

    logic [64:0]        w_trial;
    logic               w_fits;
    logic [63:0]        w_sel;

    always_comb begin
        w_trial = {r_rem, r_q[63]};
        w_fits  = (w_trial >= {1'b0, r_d});
        if (r_op == two_pkg::OP_MUL) begin
            w_sel = r_acc;
        end else if (r_op == two_pkg::OP_MOD) begin
            w_sel = r_rem;
        end else begin
            w_sel = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_as   <= AS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_as)
                AS_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_rnd <= i_req.rnd;
                        if (i_req.op == two_pkg::OP_MUL) begin
                            r_neg <= i_req.a[63] ^ i_req.b[63];
                            r_ma  <= two_pkg::mag(i_req.a);
                            r_mb  <= two_pkg::mag(i_req.b);
                            r_acc <= '0;
                            r_as  <= AS_MUL;
                        end else begin
                            r_neg <= i_req.a[63];
                            r_q   <= (i_req.op == two_pkg::OP_DIVR) ?
                                     two_pkg::mag(i_req.a) + (64'(i_req.b) >> 1) :
                                     two_pkg::mag(i_req.a);
                            r_d   <= 64'(i_req.b);
                            r_rem <= '0;
                            r_cnt <= '0;
                            r_as  <= AS_DIV;
                        end
                    end
                end
                AS_MUL: begin
                    if (r_mb == 64'd0) begin
                        r_as <= AS_RND;
                    end else begin
                        if (r_mb[0]) begin
                            r_acc <= r_acc + r_ma;
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                AS_RND: begin
                    if (r_rnd) begin
                        r_acc <= (r_acc + (64'd1 << (two_pkg::MUL_SHIFT - 1)))
                                 >> two_pkg::MUL_SHIFT;
                    end
                    r_as <= AS_OUT;
                end
                AS_DIV: begin
                    r_rem <= w_fits ? 64'(w_trial - {1'b0, r_d}) : w_trial[63:0];
                    r_q   <= {r_q[62:0], w_fits};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_as <= AS_OUT;
                    end
                end
                AS_OUT: begin
                    r_res  <= r_neg ? -$signed(w_sel) : $signed(w_sel);
                    r_done <= 1'b1;
                    r_as   <= AS_IDLE;
                end
                default: begin
                    r_as <= AS_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_as != AS_IDLE);
    assign o_rsp.res  = r_res;

endmodule

// ===== src/tracking_wheel_odometry.sv =====
// Top level of the tracking wheel odometry block: sequencer, CORDIC and pose state.
// Every product goes through a bit-serial multiplier (one multiplier bit per cycle) and
// every quotient through a restoring divider over all 64 dividend bits, shared by all
// steps; the CORDIC unit does one iteration per cycle. One item is in work at a time,
// and a finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) loads the default geometry and clears pose and history.
`timescale 1ns / 1ps

module tracking_wheel_odometry (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    two_in_if.sink                               i_item,
    two_out_if.source                            o_result,
    input  logic                                 i_cfg_we,
    input  logic [two_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [two_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // Sequencer states. Each arithmetic state issues one operation to the shared
    // unit and moves on when the result comes back.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DMUL  = 5'd1;
    localparam logic [4:0] S_DDIV  = 5'd2;
    localparam logic [4:0] S_DDIVG = 5'd3;
    localparam logic [4:0] S_DPI   = 5'd4;
    localparam logic [4:0] S_HMOD  = 5'd5;
    localparam logic [4:0] S_HMUL  = 5'd6;
    localparam logic [4:0] S_HDIV  = 5'd7;
    localparam logic [4:0] S_DIFF  = 5'd8;
    localparam logic [4:0] S_CORD  = 5'd9;
    localparam logic [4:0] S_SMUL  = 5'd10;
    localparam logic [4:0] S_RDIV  = 5'd11;
    localparam logic [4:0] S_LX1   = 5'd12;
    localparam logic [4:0] S_LX2   = 5'd13;
    localparam logic [4:0] S_LY1   = 5'd14;
    localparam logic [4:0] S_LY2   = 5'd15;
    localparam logic [4:0] S_AVG   = 5'd16;
    localparam logic [4:0] S_FOLD  = 5'd17;
    localparam logic [4:0] S_CMUL  = 5'd18;
    localparam logic [4:0] S_PX1   = 5'd19;
    localparam logic [4:0] S_PX2   = 5'd20;
    localparam logic [4:0] S_PY1   = 5'd21;
    localparam logic [4:0] S_PY2   = 5'd22;
    localparam logic [4:0] S_DONE  = 5'd23;

    // Distance phases: vertical sensor, left motor, right motor, horizontal sensor.
    localparam logic [1:0] PH_V = 2'd0;
    localparam logic [1:0] PH_L = 2'd1;
    localparam logic [1:0] PH_R = 2'd2;
    localparam logic [1:0] PH_H = 2'd3;

    localparam int  FB       = two_pkg::FRACTION_BITS;
    localparam int  AVG_W    = 38;
    localparam logic signed [19:0] HEAD_LIM = 20'sd411775;

    logic [4:0]              r_state;
    logic                    r_wait;
    logic [1:0]              r_phase;
    logic                    r_pass;
    logic                    r_neg;
    two_pkg::t_in_item       r_in;

    logic [20:0]             r_vdia;
    logic [20:0]             r_hdia;
    logic signed [21:0]      r_voff;
    logic signed [21:0]      r_hoff;
    logic [18:0]             r_gear;

    logic signed [31:0]      r_last_v;
    logic signed [31:0]      r_last_h;
    logic signed [19:0]      r_last_head;
    logic signed [31:0]      r_pose_x;
    logic signed [31:0]      r_pose_y;

    logic signed [31:0]      r_vd;
    logic signed [31:0]      r_hd;
    logic signed [19:0]      r_head;
    logic signed [63:0]      r_t;
    logic signed [35:0]      r_mleft;
    logic signed [32:0]      r_dv;
    logic signed [32:0]      r_dx;
    logic signed [21:0]      r_dh;
    logic signed [33:0]      r_chord;
    logic signed [63:0]      r_r;
    logic signed [33:0]      r_lx;
    logic signed [33:0]      r_ly;
    logic signed [33:0]      r_c;
    logic signed [33:0]      r_s;
    logic signed [35:0]      r_cx;
    logic signed [35:0]      r_cy;
    logic signed [35:0]      r_cz;
    logic [two_pkg::CI_W-1:0] r_ci;

    logic                    r_out_valid;
    two_pkg::t_out_item      r_out;

    two_pkg::t_arith_req     w_req;
    two_pkg::t_arith_rsp     w_rsp;
    logic                    w_is_arith;
    logic                    w_take;
    logic                    w_rot;
    logic signed [63:0]      w_count;
    logic [20:0]             w_dia;
    logic [18:0]             w_gear;
    logic signed [32:0]      w_dv;
    logic signed [32:0]      w_dx;
    logic signed [21:0]      w_dh;
    logic signed [35:0]      w_cdx;
    logic signed [35:0]      w_cdy;
    logic signed [35:0]      w_atan;
    logic signed [AVG_W-1:0] w_af;
    logic                    w_fneg;
    logic signed [63:0]      w_s64;
    logic signed [63:0]      w_c64;

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // Halving with rounding half away from zero.
    function automatic logic signed [63:0] half_round(input logic signed [63:0] v);
        logic [63:0] q;
        q = (two_pkg::mag(v) + 64'd1) >> 1;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    // Wraps a heading change into (-pi, pi] with two correction passes.
    function automatic logic signed [21:0] wrap_dh(input logic signed [21:0] v);
        logic signed [21:0] a;
        a = v;
        for (int k = 0; k < 2; k++) begin
            if (a > 22'(two_pkg::PI_FB)) a = a - 22'(two_pkg::TWO_PI_FB);
            if (a <= -22'(two_pkg::PI_FB)) a = a + 22'(two_pkg::TWO_PI_FB);
        end
        return a;
    endfunction

    two_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Operand selection for the current step.
    always_comb begin
        w_rot  = (r_phase == PH_V) || (r_phase == PH_H);
        w_gear = (r_gear == 19'd0) ? 19'd1 : r_gear;
        case (r_phase)
            PH_V:    w_count = 64'(r_in.vertical_count);
            PH_L:    w_count = 64'(r_in.left_motor_count);
            PH_R:    w_count = 64'(r_in.right_motor_count);
            default: w_count = 64'(r_in.horizontal_count);
        endcase
        w_dia = (r_phase == PH_H) ? r_hdia : r_vdia;

        w_is_arith = r_state inside {S_DMUL, S_DDIV, S_DDIVG, S_DPI, S_HMOD, S_HMUL,
                                     S_HDIV, S_SMUL, S_RDIV, S_LX1, S_LX2, S_LY1,
                                     S_LY2, S_CMUL, S_PX1, S_PX2, S_PY1, S_PY2};
        w_take = w_is_arith && r_wait && w_rsp.done;

        w_req = '0;
        w_req.op  = two_pkg::OP_MUL;
        w_req.rnd = 1'b1;
        case (r_state)
            S_DMUL: begin
                w_req.rnd = 1'b0;
                w_req.a   = w_count;
                w_req.b   = 64'(w_dia);
            end
            S_DDIV: begin
                w_req.op = two_pkg::OP_DIVR;
                w_req.a  = r_t;
                w_req.b  = w_rot ? two_pkg::ROT_DIV : two_pkg::MOTOR_DIV;
            end
            S_DDIVG: begin
                w_req.op = two_pkg::OP_DIVR;
                w_req.a  = r_t;
                w_req.b  = 64'(w_gear);
            end
            S_DPI: begin
                w_req.a = r_t;
                w_req.b = two_pkg::PI_Q30;
            end
            S_HMOD: begin
                w_req.op = two_pkg::OP_MOD;
                w_req.a  = two_pkg::HEAD_BASE - 64'(r_in.imu_rotation);
                w_req.b  = two_pkg::HEAD_MOD;
            end
            S_HMUL: begin
                w_req.rnd = 1'b0;
                w_req.a   = r_t;
                w_req.b   = two_pkg::PI_Q30;
            end
            S_HDIV: begin
                w_req.op = two_pkg::OP_DIVR;
                w_req.a  = r_t;
                w_req.b  = two_pkg::HSCALE;
            end
            S_SMUL: begin
                w_req.a = 64'(r_cx);
                w_req.b = 64'(r_cz);
            end
            S_CMUL: begin
                w_req.a = 64'(r_cy);
                w_req.b = 64'(r_cz);
            end
            S_RDIV: begin
                w_req.op = two_pkg::OP_DIVR;
                w_req.a  = 64'(r_chord) <<< FB;
                w_req.b  = 64'(two_pkg::mag(64'(r_dh)));
            end
            S_LX1: begin
                w_req.a = r_r;
                w_req.b = 64'(r_dx);
            end
            S_LX2: begin
                w_req.a = 64'(r_chord);
                w_req.b = 64'(r_hoff);
            end
            S_LY1: begin
                w_req.a = r_r;
                w_req.b = 64'(r_dv);
            end
            S_LY2: begin
                w_req.a = 64'(r_chord);
                w_req.b = 64'(r_voff);
            end
            S_PX1: begin
                w_req.a = 64'(r_ly);
                w_req.b = 64'(r_c);
            end
            S_PX2: begin
                w_req.a = 64'(r_lx);
                w_req.b = 64'(r_s);
            end
            S_PY1: begin
                w_req.a = 64'(r_ly);
                w_req.b = 64'(r_s);
            end
            S_PY2: begin
                w_req.a = 64'(r_lx);
                w_req.b = 64'(r_c);
            end
            default: begin
                w_req.a = '0;
                w_req.b = '0;
            end
        endcase
        w_req.start = w_is_arith && !r_wait;
    end

    // Differences of this step and the wrapped heading change.
    always_comb begin
        w_dv = 33'(r_vd) - 33'(r_last_v);
        w_dx = 33'(r_hd) - 33'(r_last_h);
        w_dh = wrap_dh(22'(r_head) - 22'(r_last_head));
    end

    // One CORDIC rotation per cycle.
    always_comb begin
        w_cdx  = r_cy >>> r_ci;
        w_cdy  = r_cx >>> r_ci;
        w_atan = 36'(two_pkg::atan_q30(5'(r_ci)));
    end

    // Mid-step heading brought into [-pi/2, pi/2]; the cosine sign flips when folded.
    always_comb begin
        logic signed [AVG_W-1:0] a;
        a = AVG_W'(r_t);
        for (int k = 0; k < 2; k++) begin
            if (a > AVG_W'(two_pkg::PI_Q30)) a = a - AVG_W'(2 * two_pkg::PI_Q30);
            if (a <= -AVG_W'(two_pkg::PI_Q30)) a = a + AVG_W'(2 * two_pkg::PI_Q30);
        end
        w_fneg = 1'b0;
        if (a > AVG_W'(two_pkg::PI_Q30 / 2)) begin
            a      = AVG_W'(two_pkg::PI_Q30) - a;
            w_fneg = 1'b1;
        end else if (a < -AVG_W'(two_pkg::PI_Q30 / 2)) begin
            a      = -AVG_W'(two_pkg::PI_Q30) - a;
            w_fneg = 1'b1;
        end
        w_af = a;
    end

    assign w_s64 = 64'(r_cy) + w_rsp.res;
    assign w_c64 = 64'(r_cx) - w_rsp.res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_vdia      <= 21'd180224;
            r_hdia      <= 21'd180224;
            r_voff      <= 22'sd57409;
            r_hoff      <= -22'sd212697;
            r_gear      <= 19'd49152;
            r_last_v    <= '0;
            r_last_h    <= '0;
            r_last_head <= '0;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
        end else begin
            // The user must write the configuration only while the block is idle; the block does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    two_pkg::CFG_VDIA: r_vdia <= i_cfg_data[20:0];
                    two_pkg::CFG_HDIA: r_hdia <= i_cfg_data[20:0];
                    two_pkg::CFG_VOFF: r_voff <= $signed(i_cfg_data);
                    two_pkg::CFG_HOFF: r_hoff <= $signed(i_cfg_data);
                    two_pkg::CFG_GEAR: r_gear <= i_cfg_data[18:0];
                    default: ;
                endcase
            end

            if (w_is_arith) begin
                r_wait <= r_wait ? !w_rsp.done : 1'b1;
            end else begin
                r_wait <= 1'b0;
            end

            if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_in <= i_item.data;
                        r_vd <= '0;
                        // Vertical source: its own sensor, else the motor average, else none.
                        if (i_item.data.vertical_ok) begin
                            r_phase <= PH_V;
                        end else if (i_item.data.motors_ok) begin
                            r_phase <= PH_L;
                        end else begin
                            r_phase <= PH_H;
                        end
                        r_state <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    if (w_take) begin
                        r_t     <= w_rsp.res;
                        r_state <= S_DDIV;
                    end
                end
                S_DDIV: begin
                    if (w_take) begin
                        if (w_rot) begin
                            r_t     <= clamp(w_rsp.res, 64'sd1 <<< 31);
                            r_state <= S_DPI;
                        end else begin
                            r_t     <= clamp(w_rsp.res, 64'sd1 <<< 38) <<< FB;
                            r_state <= S_DDIVG;
                        end
                    end
                end
                S_DDIVG: begin
                    if (w_take) begin
                        r_t     <= clamp(w_rsp.res, 64'sd1 <<< 31);
                        r_state <= S_DPI;
                    end
                end
                S_DPI: begin
                    if (w_take) begin
                        case (r_phase)
                            PH_V: begin
                                r_vd    <= sat32(w_rsp.res);
                                r_phase <= PH_H;
                                r_state <= S_DMUL;
                            end
                            PH_L: begin
                                r_mleft <= 36'(w_rsp.res);
                                r_phase <= PH_R;
                                r_state <= S_DMUL;
                            end
                            PH_R: begin
                                r_vd    <= sat32(half_round(64'(r_mleft) + w_rsp.res));
                                r_phase <= PH_H;
                                r_state <= S_DMUL;
                            end
                            default: begin
                                r_hd    <= sat32(w_rsp.res);
                                r_state <= S_HMOD;
                            end
                        endcase
                    end
                end
                S_HMOD: begin
                    if (w_take) begin
                        r_t     <= w_rsp.res;
                        r_state <= S_HMUL;
                    end
                end
                S_HMUL: begin
                    if (w_take) begin
                        r_t     <= w_rsp.res;
                        r_state <= S_HDIV;
                    end
                end
                S_HDIV: begin
                    if (w_take) begin
                        r_head <= 20'(w_rsp.res);
                        if (r_in.kind) begin
                            // Set pose: load the pose, keep this item's readings as history.
                            r_pose_x <= r_in.new_x;
                            r_pose_y <= r_in.new_y;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    r_dv <= w_dv;
                    r_dx <= w_dx;
                    r_dh <= w_dh;
                    if (w_dh == 22'sd0) begin
                        // No turn: the move is straight along the wheels.
                        r_lx    <= 34'(w_dx);
                        r_ly    <= 34'(w_dv);
                        r_state <= S_AVG;
                    end else begin
                        r_cx    <= 36'(two_pkg::CORDIC_X0);
                        r_cy    <= '0;
                        r_cz    <= 36'(w_dh) <<< (29 - FB);
                        r_ci    <= '0;
                        r_pass  <= 1'b0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (!r_cz[35]) begin
                        r_cx <= r_cx - w_cdx;
                        r_cy <= r_cy + w_cdy;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_cdx;
                        r_cy <= r_cy - w_cdy;
                        r_cz <= r_cz + w_atan;
                    end
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == two_pkg::CI_W'(two_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    if (w_take) begin
                        if (!r_pass) begin
                            r_chord <= 34'(w_s64 <<< 1);
                            r_state <= S_RDIV;
                        end else begin
                            r_s     <= 34'(w_s64);
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_RDIV: begin
                    if (w_take) begin
                        r_r     <= r_dh[21] ? -w_rsp.res : w_rsp.res;
                        r_state <= S_LX1;
                    end
                end
                S_LX1: begin
                    if (w_take) begin
                        r_t     <= w_rsp.res;
                        r_state <= S_LX2;
                    end
                end
                S_LX2: begin
                    if (w_take) begin
                        r_lx    <= 34'(clamp(r_t + w_rsp.res, 64'sd1 <<< 32));
                        r_state <= S_LY1;
                    end
                end
                S_LY1: begin
                    if (w_take) begin
                        r_t     <= w_rsp.res;
                        r_state <= S_LY2;
                    end
                end
                S_LY2: begin
                    if (w_take) begin
                        r_ly    <= 34'(clamp(r_t + w_rsp.res, 64'sd1 <<< 32));
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    // Mid-step heading in Q30: new heading minus half the change.
                    r_t     <= (64'(r_head) <<< (30 - FB)) - (64'(r_dh) <<< (29 - FB));
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_neg   <= w_fneg;
                    r_cx    <= 36'(two_pkg::CORDIC_X0);
                    r_cy    <= '0;
                    r_cz    <= 36'(w_af);
                    r_ci    <= '0;
                    r_pass  <= 1'b1;
                    r_state <= S_CORD;
                end
                S_CMUL: begin
                    if (w_take) begin
                        r_c     <= r_neg ? -34'(w_c64) : 34'(w_c64);
                        r_state <= S_PX1;
                    end
                end
                S_PX1: begin
                    if (w_take) begin
                        r_t     <= 64'(r_pose_x) + w_rsp.res;
                        r_state <= S_PX2;
                    end
                end
                S_PX2: begin
                    if (w_take) begin
                        r_pose_x <= sat32(r_t + w_rsp.res);
                        r_state  <= S_PY1;
                    end
                end
                S_PY1: begin
                    if (w_take) begin
                        r_t     <= 64'(r_pose_y) + w_rsp.res;
                        r_state <= S_PY2;
                    end
                end
                S_PY2: begin
                    if (w_take) begin
                        r_pose_y <= sat32(r_t - w_rsp.res);
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the pose to the output register once it is free.
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid       <= 1'b1;
                        r_out.pose_x_out  <= r_pose_x;
                        r_out.pose_y_out  <= r_pose_y;
                        r_out.heading_out <= r_head;
                        r_last_v          <= r_vd;
                        r_last_h          <= r_hd;
                        r_last_head       <= r_head;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // The shared unit is only started when it has finished the previous operation.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("arithmetic unit started while busy");

    // A result only comes back to a step that is waiting for it.
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_wait && w_is_arith))
        else $error("arithmetic result arrived with no step waiting");

    // An accepted item always starts the distance sequence.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == S_DMUL))
        else $error("accepted item did not start work");

    // The heading handed out stays within one turn either way.
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_head <= HEAD_LIM) && (r_head >= -HEAD_LIM)))
        else $error("heading out of range");

endmodule

// ===== verif/tracking_wheel_odometry_test.sv =====
// Self-checking testbench of the tracking wheel odometry block with a built-in pose predictor.
`timescale 1ns / 1ps

module tracking_wheel_odometry_test;
    import two_pkg::*;

    // The run stops here even if the block hangs. The limit covers the slowest updates
    // plus the idle gaps on both sides for about 1900 items, with a wide margin.
    localparam longint RUN_LIMIT   = 64'd12_000_000;
    localparam int     PHASE_ITEMS = 370;
    localparam int     HOLD_CYCLES = 3000;

    // Arctangent table of the first CORDIC iterations, Q30 radians.
    localparam longint ATAN_TBL [10] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516, 64'sd16775851, 64'sd8388437, 64'sd4194283, 64'sd2097149
    };

    typedef struct {
        t_in_item  stim;
        bit        fixed;
        t_out_item want;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    two_in_if  in_ch ();
    two_out_if out_ch ();

    tracking_wheel_odometry uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Geometry as the block should hold it, and the pose history behind it.
    longint geo_vdia, geo_hdia, geo_voff, geo_hoff, geo_gear;
    longint hist_vdist, hist_hdist, hist_heading, pose_x, pose_y;

    t_out_item pose_q[$];
    stim_row_t stim_rows[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        poses_seen = 0;
    longint    cycles = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d poses still expected", cycles, pose_q.size());
            $display("** tracking_wheel_odometry: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Fixed-point helpers of the predictor. Products are formed as unsigned
    // magnitudes and rounded half away from zero, as the block does.
    // ---------------------------------------------------------------------
    function automatic longint unsigned umag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint div_rnd(longint n, longint unsigned d);
        longint unsigned q;
        q = (umag(n) + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint mul_rnd(longint a, longint b, int sh);
        longint unsigned m;
        m = umag(a) * umag(b);
        if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clampv(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic longint sat32(longint v);
        return (v > 64'sd2147483647) ? 64'sd2147483647 :
               ((v < -64'sd2147483648) ? -64'sd2147483648 : v);
    endfunction

    function automatic longint atan_step(int i);
        if (i < 10) return ATAN_TBL[i];
        if (i <= 30) return 64'sd1 <<< (30 - i);
        return 64'sd0;
    endfunction

    // Rotation mode CORDIC on [-pi/2, pi/2], then a first-order fix by the residual angle.
    function automatic void rotate_unit(input longint z, output longint c, output longint s);
        longint x, y, dx, dy;
        x = CORDIC_X0;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        s = y + mul_rnd(x, z, 30);
        c = x - mul_rnd(y, z, 30);
    endfunction

    // Any angle: fold into (-pi, pi], then mirror into the CORDIC range.
    function automatic void sincos_any(input longint a, output longint c, output longint s);
        bit flip;
        flip = 1'b0;
        for (int k = 0; k < 2; k++) begin
            if (a > PI_Q30) a -= 2 * PI_Q30;
            if (a <= -PI_Q30) a += 2 * PI_Q30;
        end
        if (a > PI_Q30 / 2) begin
            a = PI_Q30 - a; flip = 1'b1;
        end else if (a < -(PI_Q30 / 2)) begin
            a = -PI_Q30 - a; flip = 1'b1;
        end
        rotate_unit(a, c, s);
        if (flip) c = -c;
    endfunction

    // Rotation sensor centidegrees to inches.
    function automatic longint wheel_inches(longint cnt, longint dia);
        longint a;
        a = clampv(div_rnd(cnt * dia, ROT_DIV), 64'sd1 <<< 31);
        return mul_rnd(a, PI_Q30, 30);
    endfunction

    // Drive motor counts to inches through the gear ratio; a zero ratio counts as one LSB.
    function automatic longint motor_inches(longint cnt, longint dia);
        longint g, a, b;
        g = (geo_gear > 0) ? geo_gear : 64'sd1;
        a = clampv(div_rnd(cnt * dia, MOTOR_DIV), 64'sd1 <<< 38);
        b = clampv(div_rnd(a * (64'sd1 <<< FRACTION_BITS), g), 64'sd1 <<< 31);
        return mul_rnd(b, PI_Q30, 30);
    endfunction

    function automatic void geometry_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_VDIA: geo_vdia = longint'(d[20:0]);
            CFG_HDIA: geo_hdia = longint'(d[20:0]);
            CFG_VOFF: geo_voff = longint'(signed'(d[21:0]));
            CFG_HOFF: geo_hoff = longint'(signed'(d[21:0]));
            CFG_GEAR: geo_gear = longint'(d[18:0]);
            default: ;
        endcase
    endfunction

    // Advances the pose history by one accepted item and returns the pose the block must report.
    function automatic t_out_item predict_pose(t_in_item it);
        longint vd, hd, rem, heading, dv, dx, dh, lx, ly, c, s, cc, sn, chord, r, avg;
        t_out_item o;
        if (it.vertical_ok)
            vd = wheel_inches(longint'(it.vertical_count), geo_vdia);
        else if (it.motors_ok)
            vd = div_rnd(motor_inches(longint'(it.left_motor_count), geo_vdia) +
                         motor_inches(longint'(it.right_motor_count), geo_vdia), 2);
        else
            vd = 0;
        vd = sat32(vd);
        hd = sat32(wheel_inches(longint'(it.horizontal_count), geo_hdia));

        // Compass rotation to standard heading; remainder keeps the dividend's sign.
        rem = (HEAD_BASE - longint'(it.imu_rotation)) % HEAD_MOD;
        heading = div_rnd(rem * PI_Q30, HSCALE);

        if (it.kind) begin
            pose_x = longint'(it.new_x);
            pose_y = longint'(it.new_y);
        end else begin
            dv = vd - hist_vdist;
            dx = hd - hist_hdist;
            dh = heading - hist_heading;
            for (int k = 0; k < 2; k++) begin
                if (dh > PI_FB) dh -= TWO_PI_FB;
                if (dh <= -PI_FB) dh += TWO_PI_FB;
            end
            if (dh == 0) begin
                lx = dx;
                ly = dv;
            end else begin
                // Chord of the arc: (2 sin(dh/2) / dh) * d + 2 sin(dh/2) * offset.
                rotate_unit(dh * (64'sd1 <<< (29 - FRACTION_BITS)), cc, sn);
                chord = 2 * sn;
                r = div_rnd(chord * (64'sd1 <<< FRACTION_BITS), umag(dh));
                if (dh < 0) r = -r;
                lx = mul_rnd(r, dx, 30) + mul_rnd(chord, geo_hoff, 30);
                ly = mul_rnd(r, dv, 30) + mul_rnd(chord, geo_voff, 30);
            end
            lx = clampv(lx, 64'sd1 <<< 32);
            ly = clampv(ly, 64'sd1 <<< 32);
            avg = heading * (64'sd1 <<< (30 - FRACTION_BITS)) -
                  dh * (64'sd1 <<< (29 - FRACTION_BITS));
            sincos_any(avg, c, s);
            pose_x = sat32(pose_x + mul_rnd(ly, c, 30) + mul_rnd(lx, s, 30));
            pose_y = sat32(pose_y + mul_rnd(ly, s, 30) - mul_rnd(lx, c, 30));
        end
        hist_vdist   = vd;
        hist_hdist   = hd;
        hist_heading = heading;
        o.pose_x_out  = pose_x[31:0];
        o.pose_y_out  = pose_y[31:0];
        o.heading_out = heading[19:0];
        return o;
    endfunction

    function automatic t_in_item mk(bit k, int v, bit vok, int l, int r, bit mok, int h,
                                    int rot, int nx, int ny);
        t_in_item it;
        it.kind = k;                 it.vertical_count = v;
        it.vertical_ok = vok;        it.left_motor_count = l;
        it.right_motor_count = r;    it.motors_ok = mok;
        it.horizontal_count = h;     it.imu_rotation = rot;
        it.new_x = nx;               it.new_y = ny;
        return it;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("pose %0d: %s is %0d, expected %0d", poses_seen, field, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // Sender side. Runs of zero gaps alternate with runs of random idle gaps.
    // The expectation is formed at the edge where the item is accepted.
    // ---------------------------------------------------------------------
    task automatic send_item(t_in_item it, bit fixed, t_out_item want);
        int gap;
        t_out_item p;
        gap = (((items_sent / 48) % 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        p = predict_pose(it);
        pose_q.push_back(fixed ? want : p);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_then_idle();
        in_ch.valid = 1'b0;
        while (pose_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        geometry_write(idx, val[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random part of one phase: mostly a robot driving smoothly (small steps of
    // every sensor), with set-pose items, sensor dropouts and full-range noise.
    task automatic drive_random(int n);
        int vpos, lpos, rpos, hpos, rot, sel;
        bit vok, mok;
        t_out_item none;
        none = '0;
        vpos = $urandom; lpos = $urandom; rpos = $urandom;
        hpos = $urandom_range(0, 20000) - 10000;
        rot = $urandom_range(0, 72000) - 36000;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                send_item(t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom}), 1'b0, none);
            end else if (sel < 14) begin
                send_item(mk(1'b1, vpos, $urandom, lpos, rpos, $urandom, hpos, rot,
                             $urandom, $urandom), 1'b0, none);
            end else begin
                vpos += $urandom_range(0, 4000) - 2000;
                lpos += $urandom_range(0, 600) - 300;
                rpos += $urandom_range(0, 600) - 300;
                hpos += $urandom_range(0, 4000) - 2000;
                // Mostly gentle turns; sometimes none at all, sometimes a sharp one.
                case ($urandom_range(0, 5))
                    0:       ;
                    1:       rot += $urandom_range(0, 40000) - 20000;
                    default: rot += $urandom_range(0, 1000) - 500;
                endcase
                vok = ($urandom_range(0, 3) != 0);
                mok = $urandom;
                send_item(mk(1'b0, vpos, vok, lpos, rpos, mok, hpos, rot, $urandom, $urandom),
                          1'b0, none);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver side: random stalls, zero-stall runs, and one long hold-off
    // that fills the block and backs up the sender.
    // ---------------------------------------------------------------------
    initial begin
        int gap;
        t_out_item want;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = (((poses_seen / 40) % 3) == 1) ? 0 : $urandom_range(0, 14);
            if (poses_seen == 30) gap = HOLD_CYCLES;
            repeat (gap) @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            poses_seen++;
            if (pose_q.size() == 0) begin
                $display("pose %0d arrived with nothing expected", poses_seen);
                mismatches++;
            end else begin
                want = pose_q.pop_front();
                if (out_ch.data.pose_x_out !== want.pose_x_out)
                    report("pose_x", out_ch.data.pose_x_out, want.pose_x_out);
                if (out_ch.data.pose_y_out !== want.pose_y_out)
                    report("pose_y", out_ch.data.pose_y_out, want.pose_y_out);
                if (out_ch.data.heading_out !== want.heading_out)
                    report("heading", out_ch.data.heading_out, want.heading_out);
            end
            @(negedge i_clk);
            out_ch.ready = 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence.
    // ---------------------------------------------------------------------
    initial begin
        t_out_item z;
        z = '0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;

        // Reset geometry and empty history.
        geo_vdia = 180224; geo_hdia = 180224;
        geo_voff = 57409;  geo_hoff = -212697; geo_gear = 49152;
        hist_vdist = 0; hist_hdist = 0; hist_heading = 0; pose_x = 0; pose_y = 0;

        // Directed rows. A rotation of 9000 centidegrees means heading zero, so
        // the rows marked fixed can be read off directly.
        stim_rows.push_back('{mk(0, 0, 1, 0, 0, 0, 0, 9000, 0, 0), 1'b1, z});
        stim_rows.push_back('{mk(1, 0, 1, 0, 0, 0, 0, 9000, 32'h7fffffff, 32'h80000000),
                              1'b1, '{32'sh7fffffff, 32'sh80000000, 20'sd0}});
        stim_rows.push_back('{mk(1, 0, 1, 0, 0, 0, 0, 9000, 0, 0), 1'b1, z});
        // Straight move, no heading change.
        stim_rows.push_back('{mk(0, 3600, 1, 0, 0, 0, 0, 9000, 0, 0), 1'b0, z});
        // Turn by a quarter circle with both wheels moving.
        stim_rows.push_back('{mk(0, 7200, 1, 0, 0, 0, 1800, 0, 0, 0), 1'b0, z});
        // Vertical sensor invalid: motor average stands in.
        stim_rows.push_back('{mk(0, 0, 0, 900, 1800, 1, 1800, 0, 0, 0), 1'b0, z});
        // No valid vertical source at all.
        stim_rows.push_back('{mk(0, 99, 0, 5, 7, 0, 2000, 100, 0, 0), 1'b0, z});
        // Extreme rotations and heading changes that wrap past plus or minus pi.
        stim_rows.push_back('{mk(0, 0, 1, 0, 0, 0, 0, 32'h7fffffff, 0, 0), 1'b0, z});
        stim_rows.push_back('{mk(0, 0, 1, 0, 0, 0, 0, 32'h80000000, 0, 0), 1'b0, z});
        stim_rows.push_back('{mk(0, 0, 1, 0, 0, 0, 0, 27000, 0, 0), 1'b0, z});
        stim_rows.push_back('{mk(0, 0, 1, 0, 0, 0, 0, -9000, 0, 0), 1'b0, z});
        // Huge moves that clamp the local move and saturate the pose.
        stim_rows.push_back('{mk(0, 32'h7fffffff, 1, 32'h7fffffff, 32'h7fffffff, 1,
                                 32'h7fffffff, 9000, 0, 0), 1'b0, z});
        stim_rows.push_back('{mk(0, 32'h80000000, 1, 32'h80000000, 32'h80000000, 1,
                                 32'h80000000, 9001, 0, 0), 1'b0, z});
        stim_rows.push_back('{mk(0, 0, 0, 32'h7fffffff, 32'h80000000, 1, 0, 9001, 0, 0),
                              1'b0, z});
        stim_rows.push_back('{mk(0, 0, 0, 32'h80000000, 32'h80000000, 1, 0, 45000, 0, 0),
                              1'b0, z});
        // Set pose captures readings, and a repeat of those readings leaves it alone.
        stim_rows.push_back('{mk(1, 0, 1, 0, 0, 0, 0, 9000, 32'h80000000, 32'h7fffffff),
                              1'b1, '{32'sh80000000, 32'sh7fffffff, 20'sd0}});
        stim_rows.push_back('{mk(0, 0, 1, 0, 0, 0, 0, 9000, 0, 0), 1'b1,
                              '{32'sh80000000, 32'sh7fffffff, 20'sd0}});
        stim_rows.push_back('{mk(0, -1, 1, 0, 0, 0, 1, 9001, 0, 0), 1'b0, z});
        stim_rows.push_back('{mk(0, 500, 1, 0, 0, 0, -300, 8999, 0, 0), 1'b0, z});

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[i]) send_item(stim_rows[i].stim, stim_rows[i].fixed, stim_rows[i].want);
        drive_random(PHASE_ITEMS - stim_rows.size());

        // Smallest geometry and gear ratio.
        drain_then_idle();
        write_reg(CFG_VDIA, 0);
        write_reg(CFG_HDIA, 0);
        write_reg(CFG_VOFF, -1048576);
        write_reg(CFG_HOFF, -1048576);
        write_reg(CFG_GEAR, 4096);
        drive_random(PHASE_ITEMS);

        // Largest geometry and gear ratio.
        drain_then_idle();
        write_reg(CFG_VDIA, 1048576);
        write_reg(CFG_HDIA, 1048576);
        write_reg(CFG_VOFF, 1048576);
        write_reg(CFG_HOFF, 1048576);
        write_reg(CFG_GEAR, 262144);
        drive_random(PHASE_ITEMS);

        // A zero gear ratio stands for one LSB; writes to unused indexes are ignored.
        drain_then_idle();
        write_reg(CFG_VDIA, 180224);
        write_reg(CFG_HDIA, 90112);
        write_reg(CFG_GEAR, 0);
        write_reg(3'd5, 22'h3fffff);
        write_reg(3'd7, 22'h000001);
        drive_random(PHASE_ITEMS);

        // Random mid-range geometry.
        drain_then_idle();
        write_reg(CFG_VDIA, $urandom_range(0, 1048576));
        write_reg(CFG_HDIA, $urandom_range(0, 1048576));
        write_reg(CFG_VOFF, longint'($urandom_range(0, 2097152)) - 1048576);
        write_reg(CFG_HOFF, longint'($urandom_range(0, 2097152)) - 1048576);
        write_reg(CFG_GEAR, $urandom_range(4096, 262144));
        write_reg(3'd6, $urandom);
        drive_random(PHASE_ITEMS);

        drain_then_idle();
        // Let any stray result that the block might still produce show up.
        repeat (2000) @(negedge i_clk);
        if (mismatches == 0 && pose_q.size() == 0) begin
            $display("** tracking_wheel_odometry: PASSED **");
        end else begin
            $display("** tracking_wheel_odometry: FAILED **");
        end
        $finish;
    end

endmodule
